[src/assert_macros.svh]
// Assertion macros shared by the warp encryption block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain clocked property, disabled while reset is asserted.
`define WRR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define WRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define WRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define WRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/wrr_pkg.sv]
// Package for the reduced-round warp encryption block.
// Holds the block type, tables, register codes and the round function.
`timescale 1ns / 1ps

package wrr_pkg;

  // One 128-bit block: nibble i at bits 4i+3..4i.
  typedef logic [127:0] blk_t;

  // What one cell hands to the next cell.
  typedef struct packed {
    logic valid;
    blk_t blk;
  } stage_t;

  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 64;
  localparam int unsigned RC_W    = 6;
  localparam int unsigned RC_LEN  = 41;

  // Register indexes, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_KEY_EVEN    = 2'd0,
    REG_KEY_ODD     = 2'd1,
    REG_ROUND_COUNT = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  localparam logic [63:0]     KEY_RESET   = 64'h0;
  localparam logic [RC_W-1:0] ROUND_RESET = 6'd13;

  localparam logic [3:0] SBOX [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };

  localparam logic [4:0] PERM [32] = '{
    5'd31, 5'd6,  5'd29, 5'd14, 5'd1,  5'd12, 5'd21, 5'd8,
    5'd27, 5'd2,  5'd3,  5'd0,  5'd25, 5'd4,  5'd23, 5'd10,
    5'd15, 5'd22, 5'd13, 5'd30, 5'd17, 5'd28, 5'd5,  5'd24,
    5'd11, 5'd18, 5'd19, 5'd16, 5'd9,  5'd20, 5'd7,  5'd26
  };

  localparam logic [3:0] RCON0 [RC_LEN] = '{
    4'h0, 4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'hf, 4'hf, 4'he, 4'hd, 4'ha, 4'h5, 4'ha, 4'h5,
    4'hb, 4'h6, 4'hc, 4'h9, 4'h3, 4'h6, 4'hd, 4'hb, 4'h7, 4'he, 4'hd, 4'hb, 4'h6, 4'hd,
    4'ha, 4'h4, 4'h9, 4'h2, 4'h4, 4'h9, 4'h3, 4'h7, 4'he, 4'hc, 4'h8, 4'h1, 4'h2
  };

  localparam logic [3:0] RCON1 [RC_LEN] = '{
    4'h4, 4'hc, 4'hc, 4'hc, 4'hc, 4'hc, 4'h8, 4'h4, 4'h8, 4'h4, 4'h8, 4'h4, 4'hc, 4'h8,
    4'h0, 4'h4, 4'hc, 4'h8, 4'h4, 4'hc, 4'hc, 4'h8, 4'h4, 4'hc, 4'h8, 4'h4, 4'h8, 4'h0,
    4'h4, 4'h8, 4'h0, 4'h4, 4'hc, 4'hc, 4'h8, 4'h0, 4'h0, 4'h4, 4'h8, 4'h4, 4'hc
  };

  // One full round: Feistel-style mix of the odd nibbles, round
  // constants into nibbles 1 and 3, then the nibble shuffle.
  function automatic blk_t warp_round(blk_t s, logic [63:0] key,
                                      logic [3:0] rc0, logic [3:0] rc1);
    blk_t t;
    blk_t p;
    t = s;
    p = '0;
    for (int j = 0; j < 16; j++) begin
      t[8*j+4 +: 4] = s[8*j+4 +: 4] ^ SBOX[s[8*j +: 4]] ^ key[4*j +: 4];
    end
    t[7:4]   = t[7:4] ^ rc0;
    t[15:12] = t[15:12] ^ rc1;
    for (int j = 0; j < 32; j++) begin
      p[4*PERM[j] +: 4] = t[4*j +: 4];
    end
    return p;
  endfunction

endpackage

[src/wrr_in_if.sv]
// Plaintext channel of the warp encryption block.
// Uses no package.
`timescale 1ns / 1ps

interface wrr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_low;
  logic [63:0] plain_high;

  modport source (output valid, output plain_low, output plain_high, input ready);
  modport sink (input valid, input plain_low, input plain_high, output ready);
endinterface

[src/wrr_out_if.sv]
// Ciphertext channel of the warp encryption block.
// Uses no package.
`timescale 1ns / 1ps

interface wrr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;

  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

[src/wrr_apb_regs.sv]
// Configuration registers of the warp encryption block behind an APB port.
// Depends on wrr_pkg for register codes and reset values.
`timescale 1ns / 1ps

module wrr_apb_regs #(
  parameter int unsigned MAX_ROUNDS = 41
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrr_pkg::APB_AW-1:0]    paddr,
  input  logic [wrr_pkg::APB_DW-1:0]    pwdata,
  output logic [wrr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [63:0]                   key_even_o,
  output logic [63:0]                   key_odd_o,
  output logic [wrr_pkg::RC_W-1:0]      rounds_o
);

  logic [63:0]              key_even_q, key_even_d;
  logic [63:0]              key_odd_q, key_odd_d;
  logic [wrr_pkg::RC_W-1:0] rc_q, rc_d;
  logic                     wr_en;
  wrr_pkg::reg_idx_e        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = wrr_pkg::reg_idx_e'(paddr[4:3]);

  // Write decode.
  always_comb begin
    key_even_d = key_even_q;
    key_odd_d  = key_odd_q;
    rc_d       = rc_q;
    if (wr_en) begin
      unique case (idx)
        wrr_pkg::REG_KEY_EVEN:    key_even_d = pwdata;
        wrr_pkg::REG_KEY_ODD:     key_odd_d  = pwdata;
        wrr_pkg::REG_ROUND_COUNT: rc_d       = pwdata[wrr_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_even_q <= wrr_pkg::KEY_RESET;
      key_odd_q  <= wrr_pkg::KEY_RESET;
      rc_q       <= wrr_pkg::ROUND_RESET;
    end else begin
      key_even_q <= key_even_d;
      key_odd_q  <= key_odd_d;
      rc_q       <= rc_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      wrr_pkg::REG_KEY_EVEN:    prdata = key_even_q;
      wrr_pkg::REG_KEY_ODD:     prdata = key_odd_q;
      wrr_pkg::REG_ROUND_COUNT: prdata = {{(wrr_pkg::APB_DW - wrr_pkg::RC_W){1'b0}}, rc_q};
      default:                  prdata = '0;
    endcase
  end

  // A count above MAX_ROUNDS saturates to MAX_ROUNDS.
  assign key_even_o = key_even_q;
  assign key_odd_o  = key_odd_q;
  assign rounds_o   = (rc_q > wrr_pkg::RC_W'(MAX_ROUNDS)) ? wrr_pkg::RC_W'(MAX_ROUNDS) : rc_q;

endmodule

[src/wrr_cell.sv]
// One round cell of the warp encryption chain: a pipeline stage that
// applies round ROUND when enabled. Depends on wrr_pkg.
`timescale 1ns / 1ps

module wrr_cell #(
  parameter int unsigned ROUND = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wrr_pkg::stage_t up_i,
  output logic            up_ready_o,
  output wrr_pkg::stage_t dn_o,
  input  logic            dn_ready_i,
  input  logic [63:0]     key_i,
  input  logic            active_i
);

  logic            valid_q;
  wrr_pkg::blk_t   blk_q, blk_d;

  // The stage takes a new word when it is empty or its word moves on.
  assign up_ready_o = !valid_q || dn_ready_i;

  assign blk_d = active_i ? wrr_pkg::warp_round(up_i.blk, key_i, wrr_pkg::RCON0[ROUND],
                                                wrr_pkg::RCON1[ROUND])
                          : up_i.blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_i.valid) begin
      blk_q <= blk_d;
    end
  end

  assign dn_o = '{valid: valid_q, blk: blk_q};

endmodule

[src/warp_reduced_round_encrypt.sv]
// Reduced-round warp encryption: one round cell per possible round.
// A plaintext passes through every cell register from accept to ciphertext valid, for any round count.
// Throughput is one word per cycle while out_if.ready is high; the last cell register is the output register.
// Reset is asynchronous, active low: it empties the chain and sets the keys to zero
// and the round count to 13.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module warp_reduced_round_encrypt #(
  parameter int unsigned MAX_ROUNDS = 41
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wrr_pkg::APB_AW-1:0] paddr,
  input  logic [wrr_pkg::APB_DW-1:0] pwdata,
  output logic [wrr_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  wrr_in_if.sink                     in_if,
  wrr_out_if.source                  out_if
);

  logic [63:0]              key_even, key_odd;
  logic [wrr_pkg::RC_W-1:0] rounds;
  wrr_pkg::stage_t          head;
  wrr_pkg::stage_t          stg     [MAX_ROUNDS];
  logic                     up_rdy  [MAX_ROUNDS];
  logic                     dn_rdy  [MAX_ROUNDS];
  logic [MAX_ROUNDS-1:0]    stg_v;

  // Configuration registers.
  wrr_apb_regs #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_even_o (key_even),
    .key_odd_o  (key_odd),
    .rounds_o   (rounds)
  );

  // Input word enters the first cell.
  assign head        = '{valid: in_if.valid, blk: {in_if.plain_high, in_if.plain_low}};
  assign in_if.ready = up_rdy[0];

  // Chain of round cells; even cells use the even key half.
  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_cell
    if (k == MAX_ROUNDS - 1) begin : g_last
      assign dn_rdy[k] = out_if.ready;
    end else begin : g_mid
      assign dn_rdy[k] = up_rdy[k+1];
    end

    wrr_cell #(
      .ROUND (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_i       ((k == 0) ? head : stg[(k == 0) ? 0 : k-1]),
      .up_ready_o (up_rdy[k]),
      .dn_o       (stg[k]),
      .dn_ready_i (dn_rdy[k]),
      .key_i      ((k % 2 == 1) ? key_odd : key_even),
      .active_i   (rounds > wrr_pkg::RC_W'(k))
    );

    assign stg_v[k] = stg[k].valid;
  end

  // Last cell drives the output channel.
  assign out_if.valid       = stg[MAX_ROUNDS-1].valid;
  assign out_if.cipher_low  = stg[MAX_ROUNDS-1].blk[63:0];
  assign out_if.cipher_high = stg[MAX_ROUNDS-1].blk[127:64];

  // An accepted plaintext occupies the first cell in the next cycle.
  `WRR_ASSERT(a_accept_fills, clk_i, rst_ni, in_if.valid && in_if.ready |=> stg_v[0], "accepted word lost at first cell")
  // A full chain with a stalled output must refuse new words.
  `WRR_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, (&stg_v) && !out_if.ready, !in_if.ready, "full chain accepted a word")
  // The effective round count never exceeds the number of cells.
  `WRR_ASSERT(a_round_sat, clk_i, rst_ni, rounds <= wrr_pkg::RC_W'(MAX_ROUNDS), "round count not saturated")

endmodule
